>>> src/ddeo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddeo_pkg: shared definitions for the wheel odometry block
// Widths of the shared arithmetic units, the CORDIC arctangent table and
// the request and status bundles of the iterative divider.
// ----------------------------------------------------------------------------
package ddeo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = (CORDIC_STEPS > 16) ? 5 : 4;

   localparam int NUM_W  = 64;   // dividend and quotient magnitude
   localparam int DEN_W  = 45;   // divisor magnitude
   localparam int CNT_W  = 6;    // counts NUM_W iterations
   localparam int PROD_W = 66;   // 32 x 34 signed product
   localparam int TRIG_W = 34;   // CORDIC x and y

   localparam logic [23:0] MPC_RESET = 24'd65536;
   localparam logic [19:0] WB_RESET  = 20'd32768;
   localparam logic [15:0] THR_RESET = 16'd33;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032875;
   localparam logic signed [TRIG_W-1:0] DH_SCALE    = 34'sd1367130551;
   localparam logic signed [TRIG_W-1:0] VEL_SCALE   = 34'sd1000000;

   localparam logic [1:0] REG_MPC = 2'd0;
   localparam logic [1:0] REG_WB  = 2'd1;
   localparam logic [1:0] REG_THR = 2'd2;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_stat_type;

   // arctangent of 2^-i as a binary angle
   function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] idx);
      logic [31:0] v;
      case (5'(idx))
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> src/diff_drive_encoder_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry: differential drive wheel odometry
// Turns absolute wheel encoder counts into an integrated Q16.16 pose, a
// binary-angle heading and linear and angular velocities.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     left, right counts, stamp_us
//  rsp_     out        rsp_tvalid/tready     pos_x, pos_y, heading, velocities
//  csr_     in         csr_valid/csr_ready   register index, write data
//
//  An item runs up to five divides on the 64-step bit-serial divider and
//  one or two CORDIC passes: an arc adds two divides and a second pass to
//  a straight step, and zero elapsed time skips the two velocity divides.
//  The first item after reset only latches counts. req_tready is high only
//  while idle; a result waiting in the output register holds the next item
//  in ST_OUT. Reset is synchronous; csr_ready is always high.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry
   import ddeo_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,    // left_count, right_count, stamp_us
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,    // pos_x, pos_y, heading, lin_vel, ang_vel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_L, ST_MUL_R, ST_CAP_R, ST_ROT_GO, ST_ROT_WAIT,
      ST_DH_MUL, ST_DH_CAP, ST_COR, ST_COR_END,
      ST_X_MUL, ST_X_CAP, ST_X_DIV, ST_Y_MUL, ST_Y_CAP, ST_Y_DIV,
      ST_LV_MUL, ST_LV_GO, ST_LV_DIV, ST_AV_MUL, ST_AV_GO, ST_AV_DIV, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] mpc_ff, mpc_in;
   logic [19:0] wb_ff, wb_in;
   logic [15:0] thr_ff, thr_in;

   logic        primed_ff, primed_in;
   logic [31:0] last_l_ff, last_l_in, last_r_ff, last_r_in, last_t_ff, last_t_in;
   logic [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in, pose_h_ff, pose_h_in;

   logic signed [31:0] dlt_l_ff, dlt_l_in, dlt_r_ff, dlt_r_in;
   logic [31:0]        dt_ff, dt_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in;
   logic signed [31:0] trans_ff, trans_in, rot_ff, rot_in;
   logic [31:0]        dh_ff, dh_in;
   logic               arc_ff, arc_in, sel_ff, sel_in, neg_ff, neg_in;
   logic signed [TRIG_W-1:0] c1_ff, c1_in, s1_ff, s1_in, c2_ff, c2_in, s2_ff, s2_in;
   logic signed [TRIG_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0]       cz_ff, cz_in;
   logic [1:0]               quad_ff, quad_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [31:0] dx_ff, dx_in, dy_ff, dy_in, lv_ff, lv_in, av_ff, av_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [159:0]       rsp_data_ff, rsp_data_in;

   logic signed [31:0]       mul_a;
   logic signed [TRIG_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   div_req_type  div_req;
   div_stat_type div_stat;

   // derived values
   logic signed [31:0]   dist_sat;
   logic signed [32:0]   wsum, wdiff;
   logic [32:0]          diff_mag;
   logic [PROD_W-1:0]    prod_abs;
   logic [30:0]          rot_mag;
   logic [19:0]          wb_eff;
   logic signed [PROD_W-1:0] dh_sum, rnd_sum;
   logic [31:0]          q_lo;
   logic [31:0]          q_arc, q_vel;
   logic [30:0]          q_rot;
   logic [31:0]          cor_angle, cor_aq;
   logic signed [TRIG_W-1:0] x_sh, y_sh, co, si;
   logic signed [32:0]   atan_s;
   logic                 cor_init;

   ddeo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      if (v > 58'sd2147483647)       return 32'sh7fffffff;
      else if (v < -58'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   assign dist_sat = sat32(signed'(prod_ff[PROD_W-1:8]));
   assign wsum     = 33'(dl_ff) + 33'(dr_ff);
   assign wdiff    = 33'(dr_ff) - 33'(dl_ff);
   assign diff_mag = wdiff[32] ? (~wdiff + 33'd1) : wdiff;
   assign prod_abs = prod_ff[PROD_W-1] ? (~prod_ff + 66'd1) : prod_ff;
   assign rot_mag  = rot_ff[31] ? 31'(-rot_ff) : rot_ff[30:0];
   assign wb_eff   = (wb_ff == '0) ? 20'd1 : wb_ff;
   assign dh_sum   = prod_ff + 66'sd268435456;
   assign rnd_sum  = prod_ff + 66'sd536870912;

   // quotient to signed result: keep low bits, saturate the rate and rotation
   assign q_lo  = div_stat.quotient[31:0];
   assign q_arc = neg_ff ? (~q_lo + 32'd1) : q_lo;
   assign q_rot = (div_stat.quotient > 64'd2147483647) ? 31'h7fffffff
                                                        : div_stat.quotient[30:0];
   always_comb begin
      if (neg_ff) begin
         if (div_stat.quotient >= 64'd2147483648) q_vel = 32'h80000000;
         else                                      q_vel = ~q_lo + 32'd1;
      end else begin
         if (div_stat.quotient > 64'd2147483647)  q_vel = 32'h7fffffff;
         else                                      q_vel = q_lo;
      end
   end

   // CORDIC datapath
   assign x_sh   = cx_ff >>> step_ff;
   assign y_sh   = cy_ff >>> step_ff;
   assign atan_s = signed'({1'b0, atan_bam(step_ff)});
   assign cor_aq = cor_angle + 32'h20000000;

   always_comb begin
      case (quad_ff)
         2'd0:    begin co = cx_ff;  si = cy_ff;  end
         2'd1:    begin co = -cy_ff; si = cx_ff;  end
         2'd2:    begin co = -cx_ff; si = -cy_ff; end
         default: begin co = cy_ff;  si = -cx_ff; end
      endcase
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      mpc_in       = mpc_ff;
      wb_in        = wb_ff;
      thr_in       = thr_ff;
      primed_in    = primed_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      last_t_in    = last_t_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_h_in    = pose_h_ff;
      dlt_l_in     = dlt_l_ff;
      dlt_r_in     = dlt_r_ff;
      dt_in        = dt_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      trans_in     = trans_ff;
      rot_in       = rot_ff;
      dh_in        = dh_ff;
      arc_in       = arc_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      c1_in        = c1_ff;
      s1_in        = s1_ff;
      c2_in        = c2_ff;
      s2_in        = s2_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      quad_in      = quad_ff;
      step_in      = step_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      lv_in        = lv_ff;
      av_in        = av_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = trans_ff;
      mul_b        = VEL_SCALE;
      div_req      = '0;
      cor_init     = 1'b0;
      cor_angle    = pose_h_ff;

      // drop the result once the sink takes the transfer
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            REG_MPC: mpc_in = csr_data;
            REG_WB:  wb_in  = csr_data[19:0];
            REG_THR: thr_in = csr_data[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_l_in = req_tdata[31:0];
               last_r_in = req_tdata[63:32];
               last_t_in = req_tdata[95:64];
               primed_in = 1'b1;
               if (primed_ff) begin
                  dlt_l_in = req_tdata[31:0] - last_l_ff;
                  dlt_r_in = req_tdata[63:32] - last_r_ff;
                  dt_in    = req_tdata[95:64] - last_t_ff;
                  state_in = ST_MUL_L;
               end
            end
         end
         ST_MUL_L: begin
            mul_a    = dlt_l_ff;
            mul_b    = signed'({10'b0, mpc_ff});
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            mul_a    = dlt_r_ff;
            mul_b    = signed'({10'b0, mpc_ff});
            dl_in    = dist_sat;
            state_in = ST_CAP_R;
         end
         ST_CAP_R: begin
            dr_in    = dist_sat;
            state_in = ST_ROT_GO;
         end
         ST_ROT_GO: begin
            trans_in         = wsum[32:1];
            neg_in           = wdiff[32];
            div_req.start    = 1'b1;
            div_req.dividend = {3'b0, diff_mag, 28'b0};
            div_req.divisor  = DEN_W'(wb_eff);
            state_in         = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (div_stat.done) begin
               rot_in   = neg_ff ? -signed'({1'b0, q_rot}) : signed'({1'b0, q_rot});
               state_in = ST_DH_MUL;
            end
         end
         ST_DH_MUL: begin
            mul_a    = rot_ff;
            mul_b    = DH_SCALE;
            arc_in   = (rot_ff != '0) && (32'(rot_mag) >= 32'({thr_ff, 12'b0}));
            state_in = ST_DH_CAP;
         end
         ST_DH_CAP: begin
            dh_in    = dh_sum[60:29];
            cor_init = 1'b1;
            sel_in   = 1'b0;
            state_in = ST_COR;
         end
         ST_COR: begin
            // advance one micro-rotation
            if (!cz_ff[32]) begin
               cx_in = cx_ff - y_sh;
               cy_in = cy_ff + x_sh;
               cz_in = cz_ff - atan_s;
            end else begin
               cx_in = cx_ff + y_sh;
               cy_in = cy_ff - x_sh;
               cz_in = cz_ff + atan_s;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_COR_END;
         end
         ST_COR_END: begin
            if (!sel_ff) begin
               c1_in = co;
               s1_in = si;
               if (arc_ff) begin
                  cor_angle = pose_h_ff + dh_ff;
                  cor_init  = 1'b1;
                  sel_in    = 1'b1;
                  state_in  = ST_COR;
               end else begin
                  state_in = ST_X_MUL;
               end
            end else begin
               c2_in    = co;
               s2_in    = si;
               state_in = ST_X_MUL;
            end
         end
         ST_X_MUL: begin
            mul_b    = arc_ff ? TRIG_W'(s2_ff - s1_ff) : c1_ff;
            state_in = ST_X_CAP;
         end
         ST_X_CAP: begin
            if (arc_ff) begin
               neg_in           = prod_ff[PROD_W-1] ^ rot_ff[31];
               div_req.start    = 1'b1;
               div_req.dividend = prod_abs[NUM_W-1:0];
               div_req.divisor  = DEN_W'({rot_mag, 2'b0});
               state_in         = ST_X_DIV;
            end else begin
               dx_in    = rnd_sum[61:30];
               state_in = ST_Y_MUL;
            end
         end
         ST_X_DIV: begin
            if (div_stat.done) begin
               dx_in    = q_arc;
               state_in = ST_Y_MUL;
            end
         end
         ST_Y_MUL: begin
            mul_b    = arc_ff ? TRIG_W'(c1_ff - c2_ff) : s1_ff;
            state_in = ST_Y_CAP;
         end
         ST_Y_CAP: begin
            if (arc_ff) begin
               neg_in           = prod_ff[PROD_W-1] ^ rot_ff[31];
               div_req.start    = 1'b1;
               div_req.dividend = prod_abs[NUM_W-1:0];
               div_req.divisor  = DEN_W'({rot_mag, 2'b0});
               state_in         = ST_Y_DIV;
            end else begin
               dy_in    = rnd_sum[61:30];
               state_in = (dt_ff == '0) ? ST_OUT : ST_LV_MUL;
            end
            if (!arc_ff && dt_ff == '0) begin
               lv_in = '0;
               av_in = '0;
            end
         end
         ST_Y_DIV: begin
            if (div_stat.done) begin
               dy_in    = q_arc;
               state_in = (dt_ff == '0) ? ST_OUT : ST_LV_MUL;
               if (dt_ff == '0) begin
                  lv_in = '0;
                  av_in = '0;
               end
            end
         end
         ST_LV_MUL: begin
            state_in = ST_LV_GO;
         end
         ST_LV_GO: begin
            neg_in           = prod_ff[PROD_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = prod_abs[NUM_W-1:0];
            div_req.divisor  = DEN_W'(dt_ff);
            state_in         = ST_LV_DIV;
         end
         ST_LV_DIV: begin
            if (div_stat.done) begin
               lv_in    = q_vel;
               state_in = ST_AV_MUL;
            end
         end
         ST_AV_MUL: begin
            mul_a    = rot_ff;
            state_in = ST_AV_GO;
         end
         ST_AV_GO: begin
            neg_in           = prod_ff[PROD_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = prod_abs[NUM_W-1:0];
            div_req.divisor  = {1'b0, dt_ff, 12'b0};
            state_in         = ST_AV_DIV;
         end
         ST_AV_DIV: begin
            if (div_stat.done) begin
               av_in    = q_vel;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free, then commit the pose
            if (!rsp_valid_ff || rsp_tready) begin
               pose_x_in    = pose_x_ff + dx_ff;
               pose_y_in    = pose_y_ff + dy_ff;
               pose_h_in    = pose_h_ff + dh_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {av_ff, lv_ff, pose_h_ff + dh_ff,
                               pose_y_ff + dy_ff, pose_x_ff + dx_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // load CORDIC registers: reduce by quadrant, start at the gain
      if (cor_init) begin
         quad_in = cor_aq[31:30];
         cz_in   = 33'(signed'(cor_angle - {cor_aq[31:30], 30'b0}));
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         step_in = '0;
      end

      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mpc_ff       <= MPC_RESET;
         wb_ff        <= WB_RESET;
         thr_ff       <= THR_RESET;
         primed_ff    <= 1'b0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         last_t_ff    <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mpc_ff       <= mpc_in;
         wb_ff        <= wb_in;
         thr_ff       <= thr_in;
         primed_ff    <= primed_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         last_t_ff    <= last_t_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dlt_l_ff    <= dlt_l_in;
      dlt_r_ff    <= dlt_r_in;
      dt_ff       <= dt_in;
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      trans_ff    <= trans_in;
      rot_ff      <= rot_in;
      dh_ff       <= dh_in;
      arc_ff      <= arc_in;
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      c1_ff       <= c1_in;
      s1_ff       <= s1_in;
      c2_ff       <= c2_in;
      s2_ff       <= s2_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      quad_ff     <= quad_in;
      step_ff     <= step_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      lv_ff       <= lv_in;
      av_ff       <= av_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
   end

endmodule
`default_nettype wire

>>> src/ddeo_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddeo_div: unsigned restoring divider
// One quotient bit per cycle; the quotient holds after done until next start.
// ----------------------------------------------------------------------------
module ddeo_div
   import ddeo_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_req_type  div_req,
   output div_stat_type      div_stat
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;

   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_stat.done     = done_ff;
   assign div_stat.quotient = num_ff;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: wheel odometry block
// Drives encoder count transfers with random gaps and output stalls, predicts
// every pose and velocity result in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module testbench
   import ddeo_pkg::*;
();

   localparam int HALF_PERIOD   = 6;
   localparam int WATCHDOG_MAX  = 6000;
   localparam int SETTLE_CYCLES = 450;   // longer than one arc item

   localparam logic [1:0] REG_NONE = 2'd3;   // no register at this index

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic [31:0] lin_vel;
      logic [31:0] ang_vel;
   } pose_type;

   // arctangent of 2^-i as a binary angle
   localparam logic [31:0] ARCTAN_BAM [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1, 0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;     // left_count, right_count, stamp_us
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;          // pos_x, pos_y, heading, lin_vel, ang_vel
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_data = '0;

   diff_drive_encoder_odometry DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #(HALF_PERIOD) clock = ~clock;

   // predictor copy of the registers and the odometry state
   logic [23:0] mpc_reg;
   logic [19:0] base_reg;
   logic [15:0] thr_reg;
   logic        primed;
   logic [31:0] last_left, last_right, last_stamp;
   logic [31:0] pose_x, pose_y, pose_heading;

   pose_type    pending_poses[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   logic [31:0] walk_left, walk_right, walk_stamp;

   // rotation-mode CORDIC after quadrant reduction
   function automatic void sin_cos(input logic [31:0] angle,
                                   output longint co, output longint si);
      logic [1:0]  quad;
      logic [31:0] rem;
      longint      x, y, z, nx;
      quad = 2'((angle + 32'h2000_0000) >> 30);
      rem  = angle - {quad, 30'b0};
      z = longint'(signed'(rem));
      x = 652032875;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ARCTAN_BAM[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ARCTAN_BAM[i]);
         end
         x = nx;
      end
      case (quad)
         2'd0: begin co = x;  si = y;  end
         2'd1: begin co = -y; si = x;  end
         2'd2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wheel_travel(input logic [31:0] now, input logic [31:0] prev);
      logic [31:0] delta;
      delta = now - prev;
      return clamp32((longint'(signed'(delta)) * longint'(mpc_reg)) >>> 8);
   endfunction

   // advance the pose by one transfer; returns 1 when a result is produced
   function automatic bit odometry_step(input logic [95:0] item, output pose_type res);
      logic [31:0] l, r, t, dt, dh;
      longint dl, dr, trans, rot, arot, wb, c1, s1, c2, s2, dx, dy, lv, av;
      l = item[31:0];
      r = item[63:32];
      t = item[95:64];
      res = '{default: '0};
      if (!primed) begin
         last_left = l; last_right = r; last_stamp = t;
         primed = 1'b1;
         return 0;
      end
      dl = wheel_travel(l, last_left);
      dr = wheel_travel(r, last_right);
      dt = t - last_stamp;
      last_left = l; last_right = r; last_stamp = t;
      trans = (dl + dr) >>> 1;
      wb = (base_reg == 0) ? 1 : longint'(base_reg);
      rot = ((dr - dl) * 64'sd268435456) / wb;
      if (rot > 64'sd2147483647) rot = 64'sd2147483647;
      if (rot < -64'sd2147483647) rot = -64'sd2147483647;
      arot = (rot < 0) ? -rot : rot;
      dh = 32'((rot * 64'sd1367130551 + 64'sd268435456) >>> 29);
      sin_cos(pose_heading, c1, s1);
      if (rot != 0 && arot >= (longint'(thr_reg) << 12)) begin
         sin_cos(pose_heading + dh, c2, s2);
         dx = (trans * (s2 - s1)) / (rot * 4);
         dy = (trans * (c1 - c2)) / (rot * 4);
      end else begin
         dx = (trans * c1 + 64'sd536870912) >>> 30;
         dy = (trans * s1 + 64'sd536870912) >>> 30;
      end
      pose_x = pose_x + 32'(dx);
      pose_y = pose_y + 32'(dy);
      pose_heading = pose_heading + dh;
      if (dt == 0) begin
         lv = 0; av = 0;
      end else begin
         lv = clamp32((trans * 64'sd1000000) / longint'(dt));
         av = clamp32((rot * 64'sd1000000) / (longint'(dt) << 12));
      end
      res.pos_x = pose_x;
      res.pos_y = pose_y;
      res.heading = pose_heading;
      res.lin_vel = 32'(lv);
      res.ang_vel = 32'(av);
      return 1;
   endfunction

   // pick a gap: mostly short, sometimes none for a while, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // send one encoder transfer; call at a falling edge, returns at one
   task automatic send_counts(input logic [31:0] l, input logic [31:0] r,
                              input logic [31:0] t);
      pose_type res;
      int gap;
      req_tdata  <= {t, r, l};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (odometry_step({t, r, l}, res)) pending_poses.push_back(res);
      walk_left = l; walk_right = r; walk_stamp = t;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // wait until the block is idle: results drained and no silent item in flight
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MPC: mpc_reg  = value;
         REG_WB:  base_reg = value[19:0];
         REG_THR: thr_reg  = value[15:0];
         default: ;   // no register there, drop the write
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [23:0] mpc, input logic [23:0] wb,
                             input logic [23:0] thr);
      settle();
      write_reg(REG_MPC, mpc);
      write_reg(REG_WB, wb);
      write_reg(REG_THR, thr);
   endtask

   // directed: priming, zero dt, wrap, extremes, straight and arc, ignored index
   task automatic test_directed();
      send_counts(32'h0, 32'h0, 32'd0);                 // priming transfer only
      send_counts(32'd100, 32'd100, 32'd1000);          // straight ahead
      send_counts(32'd100, 32'd100, 32'd1000);          // no motion, zero dt
      send_counts(32'd300, 32'd500, 32'd1000);          // arc, zero dt
      send_counts(32'd301, 32'd500, 32'd2000);          // small rotation, above threshold: arc
      send_counts(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'd5);  // stamp wraps
      send_counts(32'hFFFF_FFF0, 32'h0000_0010, 32'd6);
      send_counts(32'h0000_0010, 32'hFFFF_FFF0, 32'd7);
      // huge steps saturate wheel travel and rotation; zero base acts as one
      set_config(24'hFF_FFFF, 24'd0, 24'd0);
      write_reg(REG_NONE, 24'hFF_FFFF);                 // beyond the registers
      send_counts(32'h8000_0000, 32'h7FFF_FFFF, 32'd8);
      send_counts(32'h0, 32'h0, 32'd8);
      send_counts(32'd5, 32'd5, 32'd9);                 // zero rotation, zero threshold
      send_counts(32'd5, 32'd6, 32'd10);
      send_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'd11);
      // widest base, highest threshold, no distance scale
      set_config(24'd0, 24'h0F_FFFF, 24'h00_FFFF);
      send_counts(32'd1000, 32'd9000, 32'd100);
      send_counts(32'd9000, 32'd1000, 32'd200);
      set_config(24'hFF_FFFF, 24'h0F_FFFF, 24'h00_FFFF);
      send_counts(32'h4000_0000, 32'hC000_0000, 32'd300);
      send_counts(32'h4000_0100, 32'hC000_0000, 32'd300);
   endtask

   // random driving: mostly plausible motion, some noise and wild jumps
   task automatic test_random(input int count);
      int roll;
      logic [31:0] l, r, t;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            l = walk_left  + 32'($urandom_range(0, 4000)) - 32'd2000;
            r = ($urandom_range(0, 3) == 0) ? walk_right + (l - walk_left)
                : walk_right + 32'($urandom_range(0, 4000)) - 32'd2000;
            t = walk_stamp + 32'($urandom_range(0, 30000));
         end else if (roll < 90) begin
            l = $urandom(); r = $urandom(); t = $urandom();
         end else begin
            l = walk_left  + ($urandom() >> $urandom_range(0, 31));
            r = walk_right - ($urandom() >> $urandom_range(0, 31));
            t = ($urandom_range(0, 1) == 0) ? walk_stamp : walk_stamp + 32'd1;
         end
         send_counts(l, r, t);
      end
   endtask

   task automatic test_random_config();
      set_config(24'($urandom()), 24'($urandom()), 24'($urandom_range(0, 2000)));
      test_random(250);
      set_config(24'($urandom()), 24'($urandom()), 24'($urandom()));
      test_random(200);
   endtask

   // output stall: runs of no stall, mostly short stalls, a few long ones
   int stall_left = 0;
   int calm_left  = 0;
   always @(negedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 40);
         else stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   // compare each result transfer with the oldest predicted pose
   always @(posedge clock) begin
      pose_type exp_pose;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_poses.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            error_count++;
         end else begin
            exp_pose = pending_poses.pop_front();
            if (rsp_tdata[31:0] !== exp_pose.pos_x) begin
               $error("pos_x expected %h actual %h", exp_pose.pos_x, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== exp_pose.pos_y) begin
               $error("pos_y expected %h actual %h", exp_pose.pos_y, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tdata[95:64] !== exp_pose.heading) begin
               $error("heading expected %h actual %h", exp_pose.heading, rsp_tdata[95:64]);
               error_count++;
            end
            if (rsp_tdata[127:96] !== exp_pose.lin_vel) begin
               $error("lin_vel expected %h actual %h", exp_pose.lin_vel, rsp_tdata[127:96]);
               error_count++;
            end
            if (rsp_tdata[159:128] !== exp_pose.ang_vel) begin
               $error("ang_vel expected %h actual %h", exp_pose.ang_vel, rsp_tdata[159:128]);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      mpc_reg = MPC_RESET; base_reg = WB_RESET; thr_reg = THR_RESET;
      primed = 1'b0;
      last_left = '0; last_right = '0; last_stamp = '0;
      pose_x = '0; pose_y = '0; pose_heading = '0;
      walk_left = '0; walk_right = '0; walk_stamp = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_config(MPC_RESET, 24'(WB_RESET), 24'(THR_RESET));
      test_random(400);
      set_config(24'hFF_FFFF, 24'd1, 24'd0);
      test_random(150);
      test_random_config();
      set_config(24'd0, 24'h0F_FFFF, 24'h00_FFFF);
      test_random(100);
      set_config(24'd300, 24'd20000, 24'd200);
      test_random(230);
      settle();
      if (pending_poses.size() != 0) begin
         $error("%0d predicted results never arrived", pending_poses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ddeo_pkg.sv
src/ddeo_div.sv
src/diff_drive_encoder_odometry.sv
tb/sv/testbench.sv
